/* rtl/jasc_pkg.sv */
// ----------------------------------------------------------------------------
// jasc_pkg
// Shared types and constants of the joystick axis speed command unit.
// ----------------------------------------------------------------------------
`default_nettype none

package jasc_pkg;

    localparam logic [1:0] CMD_NONE = 2'd0;
    localparam logic [1:0] CMD_STOP = 2'd1;
    localparam logic [1:0] CMD_POS  = 2'd2;
    localparam logic [1:0] CMD_NEG  = 2'd3;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_CH0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_CH1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_CH2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE  = 3'd4;

    localparam logic [7:0] CENTER_RST    = 8'd128;
    localparam logic [7:0] REVERSE_RST   = 8'd0;
    localparam logic [6:0] DEAD_ZONE_RST = 7'd10;

    localparam logic [2:0]         GUARDED_AXIS = 3'd3;
    localparam logic signed [31:0] NEG_GUARD_NM = 32'sd1000000;
    localparam int unsigned        PCT_DIV      = 100;
    localparam int unsigned        PROD_W       = 15;

    // x / 100 as (x * 5243) >> 19, exact for x below 2^15
    localparam int unsigned        PCT_RECIP    = 5243;
    localparam int unsigned        PCT_SHIFT    = 19;
    localparam int unsigned        PCT_RCP_W    = 13;
    localparam int unsigned        QPROD_W      = PROD_W + PCT_RCP_W;

    localparam longint unsigned CURVE_A   = 160;
    localparam longint unsigned CURVE_B   = 9597;
    localparam longint unsigned CURVE_C   = 404400;
    localparam longint unsigned CURVE_D   = 986700;
    localparam longint unsigned CURVE_DEN = 3000000;

    typedef logic [7:0] t_curve [128];

    function automatic t_curve gen_curve();
        t_curve          t;
        longint unsigned v;
        for (int i = 0; i < 128; i++) begin
            v = CURVE_A * longint'(i) * longint'(i) * longint'(i)
              + CURVE_B * longint'(i) * longint'(i)
              + CURVE_C * longint'(i) + CURVE_D;
            t[i] = 8'(v / CURVE_DEN);
        end
        return t;
    endfunction

    localparam t_curve CURVE = gen_curve();

    typedef struct packed {
        logic load;
        logic calc;
        logic upd;
        logic scale;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

/* rtl/jasc_ctrl.sv */
// ----------------------------------------------------------------------------
// jasc_ctrl
// Sequencer: steps one word through front end, ring update, scaling, output.
// ----------------------------------------------------------------------------
`default_nettype none

module jasc_ctrl
    import jasc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  t_dp_sts      i_sts,
    output t_dp_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CALC  = 3'd1;
    localparam logic [2:0] S_UPD   = 3'd2;
    localparam logic [2:0] S_SCALE = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_SCALE;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_in_stall = 1'b0;
                    if (i_in_valid) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_CALC;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_CALC))
        else $error("accepted word did not start processing");

    a_calc_then_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC) |=> (r_state == S_UPD))
        else $error("ring update skipped");

    a_one_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.calc, o_cmd.upd, o_cmd.scale, o_cmd.emit}))
        else $error("more than one datapath step at once");

endmodule

`default_nettype wire

/* rtl/jasc_dp.sv */
// ----------------------------------------------------------------------------
// jasc_dp
// Datapath: config registers, offset and curve, speed ring with running sum,
// scaling and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module jasc_dp
    import jasc_pkg::*;
#(
    parameter int unsigned RING_DEPTH = 8
)
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  t_dp_cmd                    i_cmd,
    output t_dp_sts                    o_sts,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic [2:0]            i_axis,
    input  wire logic [9:0]            i_sample,
    input  wire logic signed [31:0]    i_position_nm,
    input  wire logic signed [31:0]    i_upper_limit_nm,
    input  wire logic [7:0]            i_speed_percent,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [2:0]                 o_axis_out,
    output logic [1:0]                 o_command,
    output logic                       o_permit_flag,
    output logic [7:0]                 o_speed,
    output logic [7:0]                 o_running_mask
);

    localparam int unsigned PW      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int unsigned MEM_N   = 3 * RING_DEPTH;
    localparam int unsigned AW      = $clog2(MEM_N);
    localparam int unsigned SW      = 8 + $clog2(RING_DEPTH);
    localparam int unsigned AVG_DIV = 2 * RING_DEPTH;

    // sum / AVG_DIV as a reciprocal multiply, exact over the SW-bit sum range
    localparam int unsigned     AVG_SH = SW + $clog2(AVG_DIV);
    localparam int unsigned     AVG_MW = SW + 2;
    localparam int unsigned     AVG_PW = SW + AVG_MW;
    localparam longint unsigned AVG_M  = ((64'd1 << AVG_SH) + AVG_DIV - 1) / AVG_DIV;

    // configuration
    logic [7:0] r_center [3];
    logic [7:0] r_reverse;
    logic [6:0] r_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center[0] <= CENTER_RST;
            r_center[1] <= CENTER_RST;
            r_center[2] <= CENTER_RST;
            r_reverse   <= REVERSE_RST;
            r_dz        <= DEAD_ZONE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CENTER_CH0: r_center[0] <= i_cfg_wdata;
                REG_CENTER_CH1: r_center[1] <= i_cfg_wdata;
                REG_CENTER_CH2: r_center[2] <= i_cfg_wdata;
                REG_REVERSE:    r_reverse   <= i_cfg_wdata;
                REG_DEAD_ZONE:  r_dz        <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // input word
    logic [2:0]         r_in_axis;
    logic [9:0]         r_in_sample;
    logic signed [31:0] r_in_pos;
    logic signed [31:0] r_in_lim;
    logic [7:0]         r_in_pct;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in_axis   <= i_axis;
            r_in_sample <= i_sample;
            r_in_pos    <= i_position_nm;
            r_in_lim    <= i_upper_limit_nm;
            r_in_pct    <= i_speed_percent;
        end
    end

    // ring state
    logic [7:0]            r_mem [MEM_N];
    logic [RING_DEPTH-1:0] r_vld [3];
    logic [PW-1:0]         r_ptr [3];
    logic [SW-1:0]         r_sum [3];
    logic [7:0]            r_active;

    // front end
    logic [1:0]        ch;
    logic [7:0]        cen;
    logic signed [8:0] diff;
    logic [7:0]        absd;
    logic [6:0]        mag;
    logic              go;
    logic              dpos;
    logic [6:0]        adj;
    logic              lim_on;
    logic              at_lim;
    logic              far_neg;
    logic [1:0]        cmd_c;
    logic              permit_c;
    logic [AW-1:0]     rd_addr;

    always_comb begin
        ch       = (r_in_axis[1:0] == 2'd3) ? 2'd2 : r_in_axis[1:0];
        cen      = r_center[ch];
        diff     = $signed({1'b0, r_in_sample[9:2]}) - $signed({1'b0, cen});
        absd     = diff[8] ? 8'(-diff) : diff[7:0];
        mag      = (absd > 8'd127) ? 7'd127 : absd[6:0];
        go       = mag > r_dz;
        adj      = mag - r_dz;
        dpos     = (!diff[8]) ^ r_reverse[r_in_axis];
        lim_on   = r_in_lim > 32'sd0;
        at_lim   = r_in_pos >= r_in_lim;
        far_neg  = r_in_pos > NEG_GUARD_NM;
        cmd_c    = CMD_NONE;
        permit_c = 1'b0;
        if (go) begin
            if (dpos) begin
                if (lim_on && at_lim) begin
                    cmd_c = CMD_STOP;
                end else begin
                    cmd_c    = CMD_POS;
                    permit_c = 1'b1;
                end
            end else if (far_neg && lim_on) begin
                cmd_c = (r_in_axis != GUARDED_AXIS) ? CMD_NEG : CMD_STOP;
            end else begin
                cmd_c    = CMD_NEG;
                permit_c = 1'b1;
            end
        end else if (r_active[r_in_axis]) begin
            cmd_c = CMD_STOP;
        end
        rd_addr = AW'(32'(ch) * RING_DEPTH) + AW'(r_ptr[ch]);
    end

    logic [1:0]    r_ch;
    logic          r_go;
    logic          r_running;
    logic [7:0]    r_curve;
    logic [PW-1:0] r_ptr_cur;
    logic [AW-1:0] r_addr;
    logic [7:0]    r_rdata;
    logic [1:0]    r_cmd;
    logic          r_permit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc) begin
            r_ch      <= ch;
            r_go      <= go;
            r_running <= r_active[r_in_axis];
            r_curve   <= CURVE[adj];
            r_ptr_cur <= r_ptr[ch];
            r_addr    <= rd_addr;
            r_rdata   <= r_mem[rd_addr];
            r_cmd     <= cmd_c;
            r_permit  <= permit_c;
        end
        if (i_cmd.upd && r_go) begin
            r_mem[r_addr] <= r_curve;
        end
    end

    // ring update
    logic [7:0]    old;
    logic [SW-1:0] n_sum;
    logic [PW-1:0] n_ptr;
    logic [SW-1:0] r_newsum;

    always_comb begin
        old   = r_vld[r_ch][r_ptr_cur] ? r_rdata : 8'd0;
        n_sum = r_sum[r_ch] - SW'(old) + SW'(r_curve);
        n_ptr = (r_ptr_cur == PW'(RING_DEPTH - 1)) ? '0 : r_ptr_cur + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            for (int c = 0; c < 3; c++) begin
                r_vld[c] <= '0;
                r_ptr[c] <= '0;
                r_sum[c] <= '0;
            end
        end else if (i_cmd.upd) begin
            if (r_go) begin
                r_active[r_in_axis]      <= 1'b1;
                r_vld[r_ch][r_ptr_cur]   <= 1'b1;
                r_ptr[r_ch]              <= n_ptr;
                r_sum[r_ch]              <= n_sum;
            end else if (r_running) begin
                r_active[r_in_axis] <= 1'b0;
                r_vld[r_ch]         <= '0;
                r_ptr[r_ch]         <= '0;
                r_sum[r_ch]         <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.upd) begin
            r_newsum <= n_sum;
        end
    end

    // scaling
    logic [AVG_PW-1:0] avg_prod;
    logic [6:0]        avg;
    logic [PROD_W-1:0] r_prod;

    assign avg_prod = AVG_PW'(r_newsum) * AVG_PW'(AVG_M);
    assign avg      = 7'(avg_prod >> AVG_SH);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scale) begin
            r_prod <= PROD_W'(avg) * PROD_W'(r_in_pct);
        end
    end

    logic [QPROD_W-1:0] qprod;
    logic [7:0]         q;
    logic [7:0]         vel;
    logic [7:0]         spd;

    always_comb begin
        qprod = QPROD_W'(r_prod) * QPROD_W'(PCT_RECIP);
        q     = 8'(qprod >> PCT_SHIFT);
        vel   = (q == 8'd0) ? 8'd1 : q;
        spd   = ((r_cmd == CMD_POS) || (r_cmd == CMD_NEG)) ? vel : 8'd0;
    end

    // output register
    assign o_sts.out_free = !o_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_axis_out     <= r_in_axis;
            o_command      <= r_cmd;
            o_permit_flag  <= r_permit;
            o_speed        <= spd;
            o_running_mask <= r_active;
        end
    end

endmodule

`default_nettype wire

/* rtl/joystick_axis_speed_command_unit.sv */
// ----------------------------------------------------------------------------
// joystick_axis_speed_command_unit
// Turns one joystick sample per motor axis into a stop / run command with a
// ring-averaged, percentage-scaled speed.
// ----------------------------------------------------------------------------
// A sequencer walks each input word through the offset and curve lookup
// (which also reads the speed ring memory), the ring and running sum update,
// the average and percentage multiply, and the output register load. The next
// word is accepted in the same cycle the result is loaded; a result held by
// output stall blocks the load of the following one, and no new word is
// accepted until that load. The ring is kept as a memory plus per-entry valid
// bits, so reset needs no clearing pass.
`default_nettype none

module joystick_axis_speed_command_unit
    import jasc_pkg::*;
#(
    parameter int unsigned RING_DEPTH = 8
)
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [2:0]            i_axis,
    input  wire logic [9:0]            i_sample,
    input  wire logic signed [31:0]    i_position_nm,
    input  wire logic signed [31:0]    i_upper_limit_nm,
    input  wire logic [7:0]            i_speed_percent,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [2:0]                 o_axis_out,
    output logic [1:0]                 o_command,
    output logic                       o_permit_flag,
    output logic [7:0]                 o_speed,
    output logic [7:0]                 o_running_mask
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    jasc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    jasc_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_axis           (i_axis),
        .i_sample         (i_sample),
        .i_position_nm    (i_position_nm),
        .i_upper_limit_nm (i_upper_limit_nm),
        .i_speed_percent  (i_speed_percent),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_axis_out       (o_axis_out),
        .o_command        (o_command),
        .o_permit_flag    (o_permit_flag),
        .o_speed          (o_speed),
        .o_running_mask   (o_running_mask)
    );

endmodule

`default_nettype wire

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Regression bench for joystick_axis_speed_command_unit. A scoreboard keeps
// its own copy of the centres, reverse mask, dead zone, speed rings and
// running mask, and works out the command word for every accepted joystick
// word. A short directed run covers centring, clamping, limits, the guarded
// axis, the speed floor and shared rings. Random phases follow under several
// register settings. Both sides idle in random bursts, and one long output
// hold-off fills the unit.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import jasc_pkg::*;

    localparam int unsigned RING_DEPTH  = 8;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned PHASE_WORDS = 80;

    typedef struct packed {
        logic [2:0]         axis;
        logic [9:0]         sample;
        logic signed [31:0] pos;
        logic signed [31:0] lim;
        logic [7:0]         pct;
    } t_joy_word;

    typedef struct packed {
        logic [2:0] axis;
        logic [1:0] cmd;
        logic       permit;
        logic [7:0] speed;
        logic [7:0] running;
    } t_axis_cmd;

    class t_axis_cmd_board;
        logic [7:0]  center [3];
        logic [7:0]  rev_mask;
        logic [6:0]  dead_zone;
        logic [7:0]  ring [3][RING_DEPTH];
        int unsigned ring_ptr [3];
        logic [7:0]  running;
        logic [7:0]  curve_tab [128];
        t_axis_cmd   cmds_due [$];
        int unsigned errors;

        function new();
            longint unsigned v;
            for (int i = 0; i < 128; i++) begin
                v = CURVE_A * i * i * i + CURVE_B * i * i + CURVE_C * i + CURVE_D;
                curve_tab[i] = 8'(v / CURVE_DEN);
            end
            for (int c = 0; c < 3; c++) begin
                center[c] = CENTER_RST;
                ring_ptr[c] = 0;
                for (int k = 0; k < RING_DEPTH; k++)
                    ring[c][k] = 8'd0;
            end
            rev_mask = REVERSE_RST;
            dead_zone = DEAD_ZONE_RST;
            running = 8'd0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
            case (idx)
                REG_CENTER_CH0: center[0] = data;
                REG_CENTER_CH1: center[1] = data;
                REG_CENTER_CH2: center[2] = data;
                REG_REVERSE:    rev_mask = data;
                REG_DEAD_ZONE:  dead_zone = data[6:0];
                default: ;
            endcase
        endfunction

        function void note_sample(t_joy_word w);
            t_axis_cmd r;
            int        ch;
            int        offs;
            int        mag;
            int        sum;
            int        vel;
            ch = (w.axis[1:0] == 2'd3) ? 2 : int'(w.axis[1:0]);
            offs = int'(w.sample[9:2]) - int'(center[ch]);
            if (offs > 127)
                offs = 127;
            else if (offs < -127)
                offs = -127;
            mag = (offs < 0) ? -offs : offs;
            r.axis = w.axis;
            r.cmd = CMD_NONE;
            r.permit = 1'b0;
            r.speed = 8'd0;
            if (mag > int'(dead_zone)) begin
                offs = (offs > 0) ? offs - int'(dead_zone) : offs + int'(dead_zone);
                if (rev_mask[w.axis])
                    offs = -offs;
                mag = (offs < 0) ? -offs : offs;
                running[w.axis] = 1'b1;
                ring[ch][ring_ptr[ch]] = curve_tab[mag];
                ring_ptr[ch] = (ring_ptr[ch] + 1 == RING_DEPTH) ? 0 : ring_ptr[ch] + 1;
                sum = 0;
                for (int k = 0; k < RING_DEPTH; k++)
                    sum += int'(ring[ch][k]);
                vel = sum / (2 * RING_DEPTH);
                vel = (vel * int'(w.pct)) / PCT_DIV;
                vel = vel & 255;
                if (vel == 0)
                    vel = 1;
                if (offs > 0) begin
                    if (w.lim > 32'sd0 && w.pos >= w.lim) begin
                        r.cmd = CMD_STOP;
                    end else begin
                        r.cmd = CMD_POS;
                        r.permit = 1'b1;
                    end
                end else if (w.pos > NEG_GUARD_NM && w.lim > 32'sd0) begin
                    r.cmd = (w.axis == GUARDED_AXIS) ? CMD_STOP : CMD_NEG;
                end else begin
                    r.cmd = CMD_NEG;
                    r.permit = 1'b1;
                end
                if (r.cmd != CMD_STOP)
                    r.speed = 8'(vel);
            end else if (running[w.axis]) begin
                running[w.axis] = 1'b0;
                r.cmd = CMD_STOP;
                ring_ptr[ch] = 0;
                for (int k = 0; k < RING_DEPTH; k++)
                    ring[ch][k] = 8'd0;
            end
            r.running = running;
            cmds_due.push_back(r);
        endfunction

        function void cmp_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
            if (got_v !== exp_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_cmd(t_axis_cmd got);
            t_axis_cmd want;
            if (cmds_due.size() == 0) begin
                $error("unexpected word: axis %0d command %0d", got.axis, got.cmd);
                errors++;
                return;
            end
            want = cmds_due.pop_front();
            cmp_field("axis_out", want.axis, got.axis);
            cmp_field("command", want.cmd, got.cmd);
            cmp_field("permit_flag", want.permit, got.permit);
            cmp_field("speed", want.speed, got.speed);
            cmp_field("running_mask", want.running, got.running);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [2:0]            i_axis;
    logic [9:0]            i_sample;
    logic signed [31:0]    i_position_nm;
    logic signed [31:0]    i_upper_limit_nm;
    logic [7:0]            i_speed_percent;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [2:0]            o_axis_out;
    logic [1:0]            o_command;
    logic                  o_permit_flag;
    logic [7:0]            o_speed;
    logic [7:0]            o_running_mask;

    t_axis_cmd_board sb = new();
    bit              tx_idle_on = 1'b1;
    bit              rx_idle_on = 1'b1;
    bit              hold_req = 1'b0;
    int unsigned     quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    joystick_axis_speed_command_unit #(
        .RING_DEPTH(RING_DEPTH)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_axis          (i_axis),
        .i_sample        (i_sample),
        .i_position_nm   (i_position_nm),
        .i_upper_limit_nm(i_upper_limit_nm),
        .i_speed_percent (i_speed_percent),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_axis_out      (o_axis_out),
        .o_command       (o_command),
        .o_permit_flag   (o_permit_flag),
        .o_speed         (o_speed),
        .o_running_mask  (o_running_mask)
    );

    function automatic t_joy_word mk(logic [2:0] axis, logic [9:0] smp, logic [31:0] pos,
                                     logic [31:0] lim, logic [7:0] pct);
        t_joy_word w;
        w.axis = axis;
        w.sample = smp;
        w.pos = pos;
        w.lim = lim;
        w.pct = pct;
        return w;
    endfunction

    // mostly deflections beyond the dead zone, some centred, some raw noise
    function automatic t_joy_word pick_word(logic [2:0] axis);
        t_joy_word w;
        int        ch;
        int        dz;
        int        s;
        int        off;
        int        lim_v;
        ch = (axis[1:0] == 2'd3) ? 2 : int'(axis[1:0]);
        dz = int'(sb.dead_zone);
        w.axis = axis;
        case ($urandom_range(0, 9))
            0, 1: off = 1000;
            2, 3: off = $urandom_range(0, dz);
            default: off = (dz < 127) ? $urandom_range(dz + 1, 127) : 127;
        endcase
        if (off == 1000) begin
            w.sample = 10'($urandom);
        end else begin
            s = int'(sb.center[ch]) + ($urandom_range(0, 1) ? off : -off);
            if (s > 255)
                s = 255;
            else if (s < 0)
                s = 0;
            w.sample = {8'(s), 2'($urandom)};
        end
        case ($urandom_range(0, 5))
            0: begin
                w.pos = $urandom;
                w.lim = $urandom;
            end
            1: begin
                lim_v = $urandom_range(1, 32'h7fffffff);
                w.lim = lim_v;
                w.pos = lim_v + $urandom_range(0, 4) - 2;
            end
            2: begin
                w.lim = -int'($urandom_range(0, 1000));
                w.pos = $urandom;
            end
            3: begin
                w.lim = $urandom_range(1, 2000000000);
                w.pos = NEG_GUARD_NM + $urandom_range(0, 3) - 1;
            end
            4: begin
                w.lim = $urandom_range(1, 32'h7fffffff);
                w.pos = $urandom;
            end
            default: begin
                w.lim = 32'sd0;
                w.pos = $urandom_range(0, 5000);
            end
        endcase
        case ($urandom_range(0, 7))
            0, 1: w.pct = 8'd100;
            2: w.pct = 8'd0;
            3: w.pct = 8'd255;
            default: w.pct = 8'($urandom);
        endcase
        return w;
    endfunction

    task automatic send_word(t_joy_word w);
        int unsigned gap;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_axis <= w.axis;
        i_sample <= w.sample;
        i_position_nm <= w.pos;
        i_upper_limit_nm <= w.lim;
        i_speed_percent <= w.pct;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_sample(w);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.cmds_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic apply_config(input logic [7:0] c0, c1, c2, rev, input logic [6:0] dz);
        logic [CFG_IDX_W-1:0] idxs [5];
        logic [7:0]           vals [5];
        idxs = '{REG_CENTER_CH0, REG_CENTER_CH1, REG_CENTER_CH2, REG_REVERSE, REG_DEAD_ZONE};
        vals = '{c0, c1, c2, rev, {1'b0, dz}};
        for (int k = 0; k < 5; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idxs[k];
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
            sb.write_reg(idxs[k], vals[k]);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin : rx_side
        int unsigned stall_left;
        stall_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall)
                sb.check_cmd({o_axis_out, o_command, o_permit_flag, o_speed, o_running_mask});
            if (hold_req) begin
                hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 13);
            end
            if (stall_left != 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("joystick_axis_speed_command_unit regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [2:0] cur_axis;
        int         nwords;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_axis = '0;
        i_sample = '0;
        i_position_nm = '0;
        i_upper_limit_nm = '0;
        i_speed_percent = '0;
        cur_axis = 3'd0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_word(mk(3'd0, 10'd512, 0, 0, 8'd100));
        send_word(mk(3'd0, 10'd1023, 0, 0, 8'd100));
        send_word(mk(3'd0, 10'd1, 0, 0, 8'd255));
        send_word(mk(3'd4, 10'd1023, 32'h7fffffff, 0, 8'd255));
        // axis 4 shares channel 0: centring it clears the ring under axis 0
        send_word(mk(3'd4, 10'd512, 0, 0, 8'd100));
        send_word(mk(3'd0, 10'd1020, 0, 0, 8'd100));
        send_word(mk(3'd0, 10'd514, 0, 0, 8'd100));
        send_word(mk(3'd0, 10'd512, 0, 0, 8'd100));
        send_word(mk(3'd1, 10'd1023, 1000, 1000, 8'd100));
        send_word(mk(3'd1, 10'd1023, 999, 1000, 8'd100));
        send_word(mk(3'd5, 10'd1023, 32'h80000000, 32'hffffffff, 8'd100));
        send_word(mk(3'd2, 10'd0, 2000000, 5, 8'd100));
        send_word(mk(3'd3, 10'd0, 2000000, 5, 8'd100));
        send_word(mk(3'd3, 10'd0, 1000000, 5, 8'd100));
        send_word(mk(3'd7, 10'd3, 32'h80000000, 32'h7fffffff, 8'd100));
        send_word(mk(3'd6, 10'd557, 0, 0, 8'd0));
        send_word(mk(3'd5, 10'd555, 0, 0, 8'd100));
        send_word(mk(3'd7, 10'd1023, 0, 0, 8'd100));
        send_word(mk(3'd2, 10'd1023, 32'hffffffff, 32'h7fffffff, 8'd200));
        settle();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: apply_config(8'd128, 8'd128, 8'd128, 8'h00, 7'd10);
                1: apply_config(8'd0, 8'd255, 8'd128, 8'hff, 7'd0);
                2: apply_config(8'd255, 8'd0, 8'd64, 8'ha5, 7'd126);
                3: apply_config(8'd100, 8'd200, 8'd30, 8'h3c, 7'd127);
                4: apply_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                7'($urandom_range(0, 40)));
                default: apply_config(8'($urandom_range(60, 200)), 8'($urandom),
                                      8'($urandom), 8'($urandom), 7'($urandom_range(0, 60)));
            endcase
            nwords = (p == 3) ? 30 : PHASE_WORDS;
            for (int n = 0; n < nwords; n++) begin
                if (n % 20 == 0) begin
                    tx_idle_on = (p != 5) && ($urandom_range(0, 2) != 0);
                    rx_idle_on = (p != 5) && ($urandom_range(0, 2) != 0);
                end
                if (p == 1 && n < 40)
                    tx_idle_on = 1'b0;
                if (p == 1 && n == 0)
                    hold_req = 1'b1;
                if ($urandom_range(0, 3) == 0)
                    cur_axis = 3'($urandom);
                send_word(pick_word(cur_axis));
            end
            settle();
        end

        repeat (20) @(posedge i_clk);
        if (sb.errors == 0)
            $display("joystick_axis_speed_command_unit regression: pass");
        else
            $display("joystick_axis_speed_command_unit regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
